// ----- rtl/tccw_pkg.sv -----
// Shared types and constants for the text console cell writer.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_CODE   = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] BLANK_CELL   = {RESET_ATTR, BLANK_CODE};

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } result_t;

  typedef struct packed {
    logic busy;
    logic strobe;
    logic read_hit;
  } ctrl_stat_t;

endpackage

// ----- rtl/tccw_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tccw_ctrl.sv -----
// Cursor tracking, put/read sequencing, clear sweep and scroll copy engine.
`timescale 1ns / 1ps

module tccw_ctrl #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF,
  localparam int unsigned CELLS  = COLUMNS * ROWS,
  localparam int unsigned AW     = $clog2(CELLS),
  localparam int unsigned RW     = $clog2(ROWS),
  localparam int unsigned CW     = $clog2(COLUMNS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  tccw_pkg::item_t      item_i,
  input  logic [7:0]           text_color_i,
  input  logic [15:0]          rdata_i,
  output tccw_pkg::ctrl_stat_t stat_o,
  output logic [RW-1:0]        row_o,
  output logic [CW-1:0]        col_o,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [15:0]          wdata_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o
);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  tccw_pkg::state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] cur_q, cur_d;     // row * COLUMNS + col, kept incrementally
  logic [AW-1:0] scan_q, scan_d;
  logic [AW-1:0] dst_q, dst_d;
  logic          copy_q, copy_d;
  logic          strobe_q, strobe_d;
  logic          hit_q, hit_d;
  logic          accept;
  logic          adv;
  logic          in_range;

  assign accept   = start && (state_q == tccw_pkg::ST_IDLE);
  assign in_range = 32'(item_i.cell_index) < CELLS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tccw_pkg::ST_CLEAR;
      row_q    <= '0;
      col_q    <= '0;
      cur_q    <= '0;
      scan_q   <= '0;
      copy_q   <= 1'b0;
      strobe_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      cur_q    <= cur_d;
      scan_q   <= scan_d;
      copy_q   <= copy_d;
      strobe_q <= strobe_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
  end

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    cur_d    = cur_q;
    scan_d   = scan_q;
    dst_d    = scan_q - COL_STEP;
    copy_d   = 1'b0;
    strobe_d = accept;
    hit_d    = accept && (item_i.operation == tccw_pkg::OP_READ) && in_range;
    we_o     = 1'b0;
    waddr_o  = cur_q;
    wdata_o  = {text_color_i, item_i.char_code};
    re_o     = 1'b0;
    raddr_o  = AW'(item_i.cell_index);
    adv      = 1'b0;

    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = scan_q;
        wdata_o = tccw_pkg::BLANK_CELL;
        if (scan_q == LAST_CELL) begin
          scan_d  = COL_STEP;
          state_d = tccw_pkg::ST_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (start) begin
          if (item_i.operation == tccw_pkg::OP_READ) begin
            re_o = 1'b1;
          end else if (item_i.char_code == tccw_pkg::NEWLINE_CODE) begin
            adv = 1'b1;
          end else begin
            we_o = 1'b1;
            if (col_q == LAST_COL) begin
              adv = 1'b1;
            end else begin
              col_d = col_q + 1'b1;
              cur_d = cur_q + 1'b1;
            end
          end
        end
        if (adv) begin
          col_d = '0;
          if (row_q == LAST_ROW) begin
            cur_d   = LAST_BASE;
            state_d = tccw_pkg::ST_SCROLL;
          end else begin
            row_d = row_q + 1'b1;
            cur_d = cur_q - AW'(col_q) + COL_STEP;
          end
        end
      end
      tccw_pkg::ST_SCROLL: begin
        // read source one row down, write it in the next cycle one row up
        re_o    = 1'b1;
        raddr_o = scan_q;
        copy_d  = 1'b1;
        if (copy_q) begin
          we_o    = 1'b1;
          waddr_o = dst_q;
          wdata_o = rdata_i;
        end
        if (scan_q == LAST_CELL) begin
          scan_d  = COL_STEP;
          state_d = tccw_pkg::ST_DRAIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      tccw_pkg::ST_DRAIN: begin
        we_o    = copy_q;
        waddr_o = dst_q;
        wdata_o = rdata_i;
        state_d = tccw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tccw_pkg::ST_CLEAR;
      end
    endcase
  end

  assign stat_o.busy     = (state_q != tccw_pkg::ST_IDLE);
  assign stat_o.strobe   = strobe_q;
  assign stat_o.read_hit = hit_q;
  assign row_o           = row_q;
  assign col_o           = col_q;

endmodule

// ----- rtl/text_console_cell_writer_top.sv -----
// Top level of the text console cell writer: ports, attribute register, screen RAM.
//
//  channel   signals                               direction  accepted when
//  item      start, busy, item_i                   in         start && !busy
//  result    result_strobe_o, result_o             out        every strobe cycle
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i  in         cfg_valid_i && cfg_ready_o
//
// An item's result appears in the cycle after it is taken; puts and reads go at one per cycle while busy is low.
// A put that scrolls holds busy while the rows are copied up, one cell copied per cycle
// through the single read and write port of the screen RAM.
// After reset a sweep writes the blank cell into all ROWS*COLUMNS entries with busy high;
// config writes are taken throughout.
`timescale 1ns / 1ps

module text_console_cell_writer_top #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tccw_pkg::item_t   item_i,
  output logic              result_strobe_o,
  output tccw_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  logic [7:0]           text_color_q;
  tccw_pkg::ctrl_stat_t stat;
  logic [RW-1:0]        row;
  logic [CW-1:0]        col;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [15:0]          ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [15:0]          ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tccw_pkg::RESET_ATTR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_color_q <= cfg_data_i;
    end
  end

  tccw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .text_color_i(text_color_q),
    .rdata_i     (ram_rdata),
    .stat_o      (stat),
    .row_o       (row),
    .col_o       (col),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .re_o        (ram_re),
    .raddr_o     (ram_raddr)
  );

  tccw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy                   = stat.busy;
  assign result_strobe_o        = stat.strobe;
  assign result_o.cell_value    = stat.read_hit ? ram_rdata : 16'h0000;
  assign result_o.cursor_row    = 5'(row);
  assign result_o.cursor_column = 7'(col);

  // one result for each item taken, in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o == $past(start && !busy))
    else $error("result strobe does not follow item intake");

  // while idle the screen is written only by an incoming put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && ram_we) |-> (start && item_i.operation == tccw_pkg::OP_PUT))
    else $error("screen write while idle without a put");

  // a scroll starts only from a put that left the cursor on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> (result_strobe_o && row == RW'(ROWS - 1) && col == '0))
    else $error("scroll started without a row advance on the bottom row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col) < COLUMNS) && (32'(row) < ROWS))
    else $error("cursor out of screen");

endmodule

// ----- bench/tb_text_console_cell_writer_top.sv -----
// Self-checking testbench for the text console cell writer top level.
`timescale 1ns / 1ps

module tb_text_console_cell_writer_top;

  localparam int unsigned COLS  = tccw_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS  = tccw_pkg::ROWS_DEF;
  localparam int unsigned CELLS = COLS * ROWS;

  // Screen, cursor and attribute shadow; predicts one result per accepted item.
  class console_scoreboard;
    logic [15:0]       screen [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [7:0]        attr;
    tccw_pkg::result_t expected_q[$];
    int unsigned       errors;

    function new();
      for (int k = 0; k < CELLS; k++) screen[k] = tccw_pkg::BLANK_CELL;
      cur_row = 0;
      cur_col = 0;
      attr    = tccw_pkg::RESET_ATTR;
      errors  = 0;
    endfunction

    function void set_attr(logic [7:0] v);
      attr = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Bottom row is left as it was after a scroll.
    function void next_line();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
        cur_row = ROWS - 1;
        for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
      end else begin
        cur_row++;
      end
    endfunction

    function void note_item(tccw_pkg::item_t it);
      tccw_pkg::result_t want;
      want = '0;
      if (it.operation == tccw_pkg::OP_READ) begin
        if (it.cell_index < CELLS) want.cell_value = screen[it.cell_index];
      end else if (it.char_code == tccw_pkg::NEWLINE_CODE) begin
        next_line();
      end else begin
        screen[cur_row * COLS + cur_col] = {attr, it.char_code};
        cur_col++;
        if (cur_col >= COLS) next_line();
      end
      want.cursor_row    = cur_row[4:0];
      want.cursor_column = cur_col[6:0];
      expected_q.push_back(want);
    endfunction

    function void check_result(tccw_pkg::result_t got);
      tccw_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: value %h row %0d col %0d",
                   $realtime, got.cell_value, got.cursor_row, got.cursor_column);
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
          got.cursor_column !== want.cursor_column) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected value %h row %0d col %0d, got value %h row %0d col %0d",
                   $realtime, want.cell_value, want.cursor_row, want.cursor_column,
                   got.cell_value, got.cursor_row, got.cursor_column);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  tccw_pkg::item_t   item_i;
  logic              result_strobe_o;
  tccw_pkg::result_t result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [7:0]        cfg_data_i;

  console_scoreboard sb;
  bit gaps_on;

  text_console_cell_writer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(result_o);
  end

  function automatic tccw_pkg::item_t put_item(logic [7:0] ch);
    tccw_pkg::item_t it;
    it.operation  = tccw_pkg::OP_PUT;
    it.char_code  = ch;
    it.cell_index = 11'($urandom);
    return it;
  endfunction

  function automatic tccw_pkg::item_t read_item(logic [10:0] idx);
    tccw_pkg::item_t it;
    it.operation  = tccw_pkg::OP_READ;
    it.char_code  = 8'($urandom);
    it.cell_index = idx;
    return it;
  endfunction

  task automatic send_item(tccw_pkg::item_t it);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 1)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  // Wait for all results and for any scroll or clear sweep to finish.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while ((sb.pending() != 0 || busy) && waited < 5000);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [7:0] v);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_attr(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly lines of text and reads around the cursor, some newline runs and noise.
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned idx;
    logic [7:0]  ch;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 12);
        for (int i = 0; i < len && sent < n; i++) begin
          ch = 8'($urandom);
          if (ch == tccw_pkg::NEWLINE_CODE) ch = tccw_pkg::BLANK_CODE;
          send_item(put_item(ch));
          sent++;
        end
        if (sent < n && $urandom_range(0, 3) != 0) begin
          send_item(put_item(tccw_pkg::NEWLINE_CODE));
          sent++;
        end
      end else if (kind < 55) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len && sent < n; i++) begin
          send_item(put_item(tccw_pkg::NEWLINE_CODE));
          sent++;
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len && sent < n; i++) begin
          case ($urandom_range(0, 5))
            0: idx = $urandom_range(0, CELLS - 1);
            1: idx = sb.cur_row * COLS + $urandom_range(0, COLS - 1);
            2: idx = (sb.cur_row > 0 ? sb.cur_row - 1 : 0) * COLS + $urandom_range(0, COLS - 1);
            3: idx = $urandom_range(CELLS - 2 * COLS, CELLS - 1);
            4: idx = $urandom_range(CELLS, 2047);
            default: idx = (sb.cur_row * COLS + sb.cur_col + CELLS - 1) % CELLS;
          endcase
          send_item(read_item(idx[10:0]));
          sent++;
        end
      end else begin
        send_item(tccw_pkg::item_t'(20'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] attr_pick;
    sb          = new();
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    gaps_on     = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, range edges, character extremes, newline
    send_item(read_item(11'd0));
    send_item(read_item(11'(CELLS - 1)));
    send_item(read_item(11'(CELLS)));
    send_item(read_item(11'd2047));
    send_item(put_item(8'h00));
    send_item(put_item(8'hFF));
    send_item(put_item(8'h41));
    send_item(read_item(11'd0));
    send_item(read_item(11'd1));
    send_item(read_item(11'd2));
    send_item(put_item(tccw_pkg::NEWLINE_CODE));
    send_item(read_item(11'(COLS)));

    write_attr(8'hFF);
    send_item(put_item(8'h5A));
    send_item(read_item(11'(COLS)));

    write_attr(8'h00);
    send_item(put_item(8'h7E));
    send_item(read_item(11'(COLS + 1)));
    send_item(put_item(tccw_pkg::NEWLINE_CODE));

    for (int p = 0; p < 5; p++) begin
      attr_pick = (p == 2) ? 8'hF0 : 8'($urandom);
      write_attr(attr_pick);
      gaps_on = (p != 2);
      run_random(190);
    end

    settle();
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0d results never arrived", sb.pending());
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
